// ===== rtl/uxpc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the URL XOR percent codec.
// No dependencies; used by every module of the codec.
package uxpc_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;   // '%'
   localparam logic [7:0] XOR_MASK = 8'h02;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;
   localparam int QUEUE_DEPTH = 4;

   // One queued job: up to three symbols, expanded or sent raw by the back end
   typedef struct packed {
      logic [2:0][7:0] sym;
      logic            expand;
      logic [1:0]      nsym;
      logic            last;
   } uxpc_job_type;

   // Unreserved characters: A-Z a-z 0-9 - _ . ~
   function automatic logic plain_char(input logic [7:0] c);
      plain_char = c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
                             8'h2D, 8'h5F, 8'h2E, 8'h7E};
   endfunction

   // Uppercase hex digit for a nibble
   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      if (v < 4'd10) begin
         hex_digit = 8'h30 + {4'h0, v};
      end else begin
         hex_digit = 8'h37 + {4'h0, v};
      end
   endfunction

   // Value of a hex digit; anything else counts as zero
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         t = c - 8'h30;
      end else if (c inside {[8'h41:8'h46]}) begin
         t = c - 8'h37;
      end else if (c inside {[8'h61:8'h66]}) begin
         t = c - 8'h57;
      end
      hex_value = t[3:0] & NIBBLE_MASK;
   endfunction

endpackage

// ===== rtl/uxpc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input words, runs the inner encode or the decode chain,
// and pushes at most one job per word into the queue. Depends on uxpc_pkg.
module uxpc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_byte,
   input  logic                  req_last,
   input  logic                  push_ready,
   output logic                  push_valid,
   output uxpc_pkg::uxpc_job_type push_job
);

   typedef enum logic [1:0] {PH_IDLE, PH_PCT, PH_HELD} phase_type;

   logic       mode_ff;
   phase_type  ph1_ff, ph1_in, ph2_ff, ph2_in;
   logic [7:0] held1_ff, held1_in, held2_ff, held2_in;
   logic       parity_ff, parity_in;
   logic       accept;

   logic [1:0]      pv;
   logic [1:0][7:0] pc;
   logic [1:0]      pf;
   logic [7:0]      x;
   logic [7:0]      mask;
   logic [1:0]      n;
   uxpc_pkg::uxpc_job_type job;

   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept && (n != 2'd0);
   assign push_job   = job;

   always_comb begin
      ph1_in    = ph1_ff;
      ph2_in    = ph2_ff;
      held1_in  = held1_ff;
      held2_in  = held2_ff;
      parity_in = parity_ff;
      pv        = 2'b00;
      pc        = '0;
      pf        = 2'b00;
      x         = 8'h00;
      mask      = 8'h00;
      n         = 2'd0;
      job       = '0;
      job.last  = req_last;
      if (!mode_ff) begin
         // Inner encode with XOR; the back end applies the outer encode
         job.expand = 1'b1;
         mask = parity_ff ? uxpc_pkg::XOR_MASK : 8'h00;
         if (uxpc_pkg::plain_char(req_byte)) begin
            job.sym[0] = req_byte ^ mask;
            n = 2'd1;
         end else begin
            job.sym[0] = uxpc_pkg::PCT_CHAR ^ mask;
            job.sym[1] = uxpc_pkg::hex_digit(req_byte[7:4]) ^ (mask ^ uxpc_pkg::XOR_MASK);
            job.sym[2] = uxpc_pkg::hex_digit(req_byte[3:0]) ^ mask;
            n = 2'd3;
         end
         parity_in = ~parity_ff;
      end else begin
         // First decode stage: up to two characters passed on
         case (ph1_ff)
            PH_PCT: begin
               if (req_last) begin
                  pv = 2'b11;
                  pc[0] = uxpc_pkg::PCT_CHAR;
                  pc[1] = req_byte;
                  pf = 2'b10;
                  ph1_in = PH_IDLE;
               end else begin
                  held1_in = req_byte;
                  ph1_in = PH_HELD;
               end
            end
            PH_HELD: begin
               pv[0] = 1'b1;
               pc[0] = {uxpc_pkg::hex_value(held1_ff), uxpc_pkg::hex_value(req_byte)};
               pf[0] = req_last;
               ph1_in = PH_IDLE;
            end
            default: begin
               if (req_byte == uxpc_pkg::PCT_CHAR && !req_last) begin
                  ph1_in = PH_PCT;
               end else begin
                  pv[0] = 1'b1;
                  pc[0] = req_byte;
                  pf[0] = req_last;
                  ph1_in = PH_IDLE;
               end
            end
         endcase
         // XOR, then the second decode stage, for each passed character
         for (int i = 0; i < 2; i++) begin
            if (pv[i]) begin
               x = pc[i] ^ (parity_in ? uxpc_pkg::XOR_MASK : 8'h00);
               parity_in = ~parity_in;
               case (ph2_in)
                  PH_PCT: begin
                     if (pf[i]) begin
                        job.sym[n] = uxpc_pkg::PCT_CHAR;
                        n = n + 2'd1;
                        job.sym[n] = x;
                        n = n + 2'd1;
                        ph2_in = PH_IDLE;
                     end else begin
                        held2_in = x;
                        ph2_in = PH_HELD;
                     end
                  end
                  PH_HELD: begin
                     job.sym[n] = {uxpc_pkg::hex_value(held2_in), uxpc_pkg::hex_value(x)};
                     n = n + 2'd1;
                     ph2_in = PH_IDLE;
                  end
                  default: begin
                     if (x == uxpc_pkg::PCT_CHAR && !pf[i]) begin
                        ph2_in = PH_PCT;
                     end else begin
                        job.sym[n] = x;
                        n = n + 2'd1;
                        ph2_in = PH_IDLE;
                     end
                  end
               endcase
            end
         end
      end
      job.nsym = n;
      // End of string: start the next one clean
      if (req_last) begin
         ph1_in    = PH_IDLE;
         ph2_in    = PH_IDLE;
         held1_in  = 8'h00;
         held2_in  = 8'h00;
         parity_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         ph1_ff    <= PH_IDLE;
         ph2_ff    <= PH_IDLE;
         held1_ff  <= 8'h00;
         held2_ff  <= 8'h00;
         parity_ff <= 1'b0;
      end else if (csr_we) begin
         mode_ff   <= csr_data;
         ph1_ff    <= PH_IDLE;
         ph2_ff    <= PH_IDLE;
         held1_ff  <= 8'h00;
         held2_ff  <= 8'h00;
         parity_ff <= 1'b0;
      end else if (accept) begin
         ph1_ff    <= ph1_in;
         ph2_ff    <= ph2_in;
         held1_ff  <= held1_in;
         held2_ff  <= held2_in;
         parity_ff <= parity_in;
      end
   end

endmodule

// ===== rtl/uxpc_queue.sv =====
`timescale 1ns / 1ps
// Job queue between front and back end; the head entry is read in place.
// Depends on uxpc_pkg.
module uxpc_queue #(
   parameter int Depth = uxpc_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  uxpc_pkg::uxpc_job_type push_job,
   output logic                   not_full,
   input  logic                   pop,
   output logic                   head_valid,
   output uxpc_pkg::uxpc_job_type head_job
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   uxpc_pkg::uxpc_job_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign not_full   = (count_ff != CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && not_full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/uxpc_back.sv =====
`timescale 1ns / 1ps
// Back end: walks the head job one word a cycle unless stalled, applying the outer
// percent encode where asked, into the registered result stage. Depends on uxpc_pkg.
module uxpc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  uxpc_pkg::uxpc_job_type head_job,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_byte,
   output logic                   rsp_last
);

   logic [1:0] sym_idx_ff, sym_idx_in, sub_idx_ff, sub_idx_in;
   logic       rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic [7:0] cur;
   logic       wide, sym_end, job_end, fire;

   assign cur     = head_job.sym[sym_idx_ff];
   assign wide    = head_job.expand && !uxpc_pkg::plain_char(cur);
   assign sym_end = !wide || (sub_idx_ff == 2'd2);
   assign job_end = sym_end && (sym_idx_ff == head_job.nsym - 2'd1);
   assign fire    = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop     = fire && job_end;

   always_comb begin
      sym_idx_in   = sym_idx_ff;
      sub_idx_in   = sub_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = job_end && head_job.last;
         case (sub_idx_ff)
            2'd0:    rsp_byte_in = wide ? uxpc_pkg::PCT_CHAR : cur;
            2'd1:    rsp_byte_in = uxpc_pkg::hex_digit(cur[7:4]);
            default: rsp_byte_in = uxpc_pkg::hex_digit(cur[3:0]);
         endcase
         if (job_end) begin
            sym_idx_in = 2'd0;
            sub_idx_in = 2'd0;
         end else if (sym_end) begin
            sym_idx_in = sym_idx_ff + 2'd1;
            sub_idx_in = 2'd0;
         end else begin
            sub_idx_in = sub_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_idx_ff   <= 2'd0;
         sub_idx_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sym_idx_ff   <= sym_idx_in;
         sub_idx_ff   <= sub_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ===== rtl/url_xor_percent_codec_top.sv =====
`timescale 1ns / 1ps
// URL XOR percent codec, top level. Instantiates uxpc_front, uxpc_queue and
// uxpc_back; depends on uxpc_pkg.
//
// Usage:
//   req_ channel: one input word a cycle (req_byte, req_last on the final byte).
//   rsp_ channel: output words (rsp_byte, rsp_last on the final word of a string).
//   csr_we/csr_data: write the mode (0 encode chain, 1 decode chain) while idle;
//   a write also restarts the string.
// Path: an accepted input word is written into the job queue; the back end then
//   registers its first output word into the result stage, which drives rsp_valid.
// Throughput: the back end sends one word a cycle unless stalled by rsp_ready;
//   an input word gives 1 to 9 words encoding, 0 to 2 decoding. The front end
//   accepts a word every cycle while the job queue (QueueDepth entries) has room.
// Reset: synchronous; clears mode to encode, empties the queue, drops any
//   pending output and starts a new string.
// Receiver stall: the result word holds on rsp_ while rsp_ready is low; the
//   back end waits, the queue fills, and then req_ready drops.
module url_xor_percent_codec_top #(
   parameter int QueueDepth = uxpc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_byte,
   output logic       rsp_last
);

   logic                   push_valid, push_ready;
   uxpc_pkg::uxpc_job_type push_job;
   logic                   head_valid, pop;
   uxpc_pkg::uxpc_job_type head_job;

   // Classify and run the inner chain; at most one job per word
   uxpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_data   (csr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_byte   (req_byte),
      .req_last   (req_last),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // Decouple front and back so each can stall on its own
   uxpc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_job   (push_job),
      .not_full   (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Expand and send one word a cycle while the receiver keeps up
   uxpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_byte   (rsp_byte),
      .rsp_last   (rsp_last)
   );

endmodule

// ===== rtl/uxpc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the codec top level, bound in below.
// Depends only on the top level's ports.
module uxpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_byte,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte,
   input logic       rsp_last
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last))
      else $error("stalled result word changed");

   // Hold a stalled input word
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_byte) && $stable(req_last))
      else $error("stalled input word changed");

   // Drop any pending output at reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Empty queue after reset, so input is taken at once
   a_req_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

endmodule

bind url_xor_percent_codec_top uxpc_checker u_uxpc_checker (.*);

// ===== sim/url_xor_percent_codec_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for url_xor_percent_codec_top: encode and decode chains,
// random gaps on both sides, a long receiver stall and drain pauses.
// Depends on uxpc_pkg and url_xor_percent_codec_top.
module url_xor_percent_codec_top_tb;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;
   localparam logic [1:0] PM_IDLE = 2'd0;
   localparam logic [1:0] PM_PCT = 2'd1;
   localparam logic [1:0] PM_HELD = 2'd2;
   localparam int   SETTLE_CYCLES = 16;     // well past the path through the job queue and result stage
   localparam int   HOLD_CYCLES = 300;      // long receiver stall
   localparam int   CYCLE_LIMIT = 100000;
   localparam int   IDLE_PERCENT = 24;
   localparam string PLAIN_SET = "AZaz09-_.~MmQq5";

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } url_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic       csr_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_byte = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_byte;
   logic       rsp_last;

   url_word_type input_words[$];      // words waiting for the driver
   url_word_type expected_words[$];   // predicted output words, oldest first
   logic [7:0]   step_bytes[$];       // output of the word being predicted

   // Predictor state: mode and the stream state of both decode stages
   logic       pm_mode = MODE_ENCODE;
   logic [1:0] pm_ph1 = PM_IDLE;
   logic [7:0] pm_held1 = 8'h00;
   logic       pm_parity = 1'b0;
   logic [1:0] pm_ph2 = PM_IDLE;
   logic [7:0] pm_held2 = 8'h00;

   logic       calm = 1'b0;         // no idling on either side while set
   logic       hold_kick = 1'b0;
   int         hold_left = 0;
   int         errors = 0;
   int         cycle_count = 0;

   url_xor_percent_codec_top dut (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_data (csr_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_byte (req_byte),
      .req_last (req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_byte (rsp_byte),
      .rsp_last (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic url_safe_byte(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
             (c >= "0" && c <= "9") || c == "-" || c == "_" || c == "." || c == "~";
   endfunction

   function automatic logic [7:0] nibble_char(input logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
   endfunction

   // Non-hex characters count as zero
   function automatic logic [3:0] char_nibble(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= "0" && c <= "9") v = c - 8'h30;
      else if (c >= "A" && c <= "F") v = c - 8'h37;
      else if (c >= "a" && c <= "f") v = c - 8'h57;
      return v[3:0];
   endfunction

   // Flip bit 1 of every odd-positioned character, then advance the position
   function automatic logic [7:0] flip_odd(input logic [7:0] c);
      logic [7:0] r;
      r = pm_parity ? (c ^ uxpc_pkg::XOR_MASK) : c;
      pm_parity = ~pm_parity;
      return r;
   endfunction

   task automatic put_out(input logic [7:0] c);
      if (step_bytes.size() < 9) step_bytes.push_back(c);
   endtask

   task automatic escape_outer(input logic [7:0] c);
      if (url_safe_byte(c)) begin
         put_out(c);
      end else begin
         put_out(uxpc_pkg::PCT_CHAR);
         put_out(nibble_char(c[7:4]));
         put_out(nibble_char(c[3:0]));
      end
   endtask

   task automatic encode_char(input logic [7:0] c);
      if (url_safe_byte(c)) begin
         escape_outer(flip_odd(c));
      end else begin
         escape_outer(flip_odd(uxpc_pkg::PCT_CHAR));
         escape_outer(flip_odd(nibble_char(c[7:4])));
         escape_outer(flip_odd(nibble_char(c[3:0])));
      end
   endtask

   // Second decode stage: works on the XORed text
   task automatic unescape_outer(input logic [7:0] c, input logic fin);
      if (pm_ph2 == PM_PCT) begin
         if (fin) begin
            put_out(uxpc_pkg::PCT_CHAR);
            put_out(c);
            pm_ph2 = PM_IDLE;
         end else begin
            pm_held2 = c;
            pm_ph2 = PM_HELD;
         end
      end else if (pm_ph2 == PM_HELD) begin
         put_out({char_nibble(pm_held2), char_nibble(c)});
         pm_ph2 = PM_IDLE;
      end else if (c == uxpc_pkg::PCT_CHAR && !fin) begin
         pm_ph2 = PM_PCT;
      end else begin
         put_out(c);
         pm_ph2 = PM_IDLE;
      end
   endtask

   // First decode stage: works on the raw input text
   task automatic unescape_inner(input logic [7:0] c, input logic fin);
      if (pm_ph1 == PM_PCT) begin
         if (fin) begin
            // lone escape at the end: pass '%' and the character literally
            unescape_outer(flip_odd(uxpc_pkg::PCT_CHAR), 1'b0);
            unescape_outer(flip_odd(c), 1'b1);
            pm_ph1 = PM_IDLE;
         end else begin
            pm_held1 = c;
            pm_ph1 = PM_HELD;
         end
      end else if (pm_ph1 == PM_HELD) begin
         unescape_outer(flip_odd({char_nibble(pm_held1), char_nibble(c)}), fin);
         pm_ph1 = PM_IDLE;
      end else if (c == uxpc_pkg::PCT_CHAR && !fin) begin
         pm_ph1 = PM_PCT;
      end else begin
         unescape_outer(flip_odd(c), fin);
         pm_ph1 = PM_IDLE;
      end
   endtask

   task automatic clear_stream();
      pm_ph1 = PM_IDLE;
      pm_held1 = 8'h00;
      pm_parity = 1'b0;
      pm_ph2 = PM_IDLE;
      pm_held2 = 8'h00;
   endtask

   // Work out the output words of one accepted input word
   task automatic predict_word(input logic [7:0] b, input logic last);
      url_word_type w;
      step_bytes.delete();
      if (pm_mode == MODE_ENCODE) encode_char(b);
      else unescape_inner(b, last);
      foreach (step_bytes[i]) begin
         w.data = step_bytes[i];
         w.last = last && (i == step_bytes.size() - 1);
         expected_words.push_back(w);
      end
      if (last) clear_stream();
   endtask

   // ------------------------------------------------------ driver and monitor

   // Driver: offer queued words, hold each until accepted, idle at random
   always @(posedge clock) begin
      url_word_type nxt;
      logic         offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_word(req_byte, req_last);
         if (!req_valid || req_ready) begin
            offer = input_words.size() != 0 &&
                    (calm || $urandom_range(99) >= IDLE_PERCENT);
            if (offer) begin
               nxt = input_words.pop_front();
               req_valid <= 1'b1;
               req_byte <= nxt.data;
               req_last <= nxt.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver stall, counted here so the monitor only looks at hold_left
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: check each accepted word against the oldest expectation
   always @(posedge clock) begin
      url_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: rsp_byte %h rsp_last %b", rsp_byte, rsp_last);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_byte !== want.data) begin
                  $error("rsp_byte expected %h actual %h", want.data, rsp_byte);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("rsp_last expected %b actual %b", want.last, rsp_last);
                  errors++;
               end
            end
         end
         rsp_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic queue_word(input logic [7:0] b, input logic last);
      url_word_type w;
      w.data = b;
      w.last = last;
      input_words.push_back(w);
   endtask

   // Queue a whole string, last flag on its final byte
   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_word(s[i], i == s.len() - 1);
   endtask

   function automatic logic [7:0] random_plain();
      return PLAIN_SET[$urandom_range(PLAIN_SET.len() - 1)];
   endfunction

   // Mostly upper-case hex, some lower case, the odd non-hex character
   function automatic logic [7:0] random_hex();
      int r;
      r = $urandom_range(99);
      if (r < 60) return nibble_char(4'($urandom_range(15)));
      if (r < 90) return 8'h61 + 8'($urandom_range(5));
      return 8'($urandom_range(255));
   endfunction

   // Queue random strings until at least target words are waiting
   task automatic queue_strings(input logic decode, input int target);
      logic [7:0] text[$];
      int         queued;
      int         len;
      int         r;
      queued = 0;
      while (queued < target) begin
         text.delete();
         len = $urandom_range(1, 10);
         while (text.size() < len) begin
            r = $urandom_range(99);
            if (!decode) begin
               text.push_back(r < 50 ? random_plain() : 8'($urandom_range(255)));
            end else if (r < 30) begin
               text.push_back(uxpc_pkg::PCT_CHAR);
               text.push_back(random_hex());
               text.push_back(random_hex());
            end else if (r < 45) begin
               // escaped '%' or its XORed twin, to open a second-level escape
               text.push_back(uxpc_pkg::PCT_CHAR);
               text.push_back("2");
               text.push_back($urandom_range(1) ? "5" : "7");
            end else if (r < 80) begin
               text.push_back(random_plain());
            end else begin
               text.push_back(8'($urandom_range(255)));
            end
         end
         // break the tail now and then: a lone '%' or '%' and one digit
         if (decode && $urandom_range(9) == 0) begin
            text.push_back(uxpc_pkg::PCT_CHAR);
            if ($urandom_range(1)) text.push_back(random_hex());
         end
         foreach (text[i]) queue_word(text[i], i == text.size() - 1);
         queued += text.size();
      end
   endtask

   // Wait until every word is sent and every expected word has come back
   task automatic settle();
      do @(negedge clock);
      while (input_words.size() != 0 || req_valid || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Write the mode while idle; the write also restarts the string
   task automatic write_mode(input logic m);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_data <= m;
      @(posedge clock);
      csr_we <= 1'b0;
      pm_mode = m;
      clear_stream();
      @(negedge clock);
   endtask

   task automatic kick_hold();
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Encode: byte extremes, every unreserved class, space and '%'
      write_mode(MODE_ENCODE);
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_text("Az9-_.~ %");
      settle();

      // Decode: plain escape, lone '%' at the end, '%' plus one digit at the end,
      // non-hex digits, double escape
      write_mode(MODE_DECODE);
      queue_text("%41");
      queue_text("%");
      queue_text("%4");
      queue_text("%zG");
      queue_text("%2541");
      // half-read escape, then a mode write that must drop it
      queue_word(uxpc_pkg::PCT_CHAR, 1'b0);
      queue_word("4", 1'b0);
      settle();
      write_mode(MODE_ENCODE);

      // Encode with a long receiver stall while the sender keeps offering
      queue_strings(MODE_ENCODE, 50);
      kick_hold();
      settle();

      // Decode, pausing halfway until everything has drained
      write_mode(MODE_DECODE);
      queue_strings(MODE_DECODE, 25);
      settle();
      queue_strings(MODE_DECODE, 25);
      settle();

      // Encode at full rate on both sides
      calm = 1'b1;
      write_mode(MODE_ENCODE);
      queue_strings(MODE_ENCODE, 45);
      settle();
      calm = 1'b0;

      // Decode with a stall, then a closing encode phase
      write_mode(MODE_DECODE);
      queue_strings(MODE_DECODE, 60);
      kick_hold();
      settle();
      write_mode(MODE_ENCODE);
      queue_strings(MODE_ENCODE, 50);
      settle();

      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/uxpc_pkg.sv
rtl/uxpc_front.sv
rtl/uxpc_queue.sv
rtl/uxpc_back.sv
rtl/url_xor_percent_codec_top.sv
rtl/uxpc_checker.sv
sim/url_xor_percent_codec_top_tb.sv
